// ----- rtl/csr_pkg.sv -----
// Shared types and constants of the CAN segment reassembler.
// Used by csr_ctrl, csr_datapath and can_segment_reassembler; depends on nothing.
package csr_pkg;

  localparam int IN_W    = 104;  // 97 payload bits padded to whole bytes
  localparam int OUT_W   = 88;   // 83 payload bits padded to whole bytes
  localparam int ID_W    = 29;
  localparam int CMP_W   = 10;   // holds lengths and offsets up to the largest buffer

  localparam logic [ID_W-1:0] RX_ID_BASE_RST = 29'h500;
  localparam logic [ID_W:0]   ID_WINDOW      = 30'd32;
  localparam logic [3:0]      MIN_DLC        = 4'd2;
  localparam logic [3:0]      MAX_DLC        = 4'd8;
  localparam logic [3:0]      CHUNK_BYTES    = 4'd8;
  localparam logic [3:0]      LAST_CHUNK_IDX = 4'd15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;   // capture the input word
    logic check;   // apply the header to the sequence state
    logic wr;      // write one payload byte
    logic start;   // set up read-out of the first chunk
    logic rd;      // one step of the chunk read
    logic emit;    // load the output register
    logic next;    // set up read-out of the following chunk
  } csr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic filt_ok;
    logic seq_ok;
    logic fits;
    logic done;
    logic wr_last;
    logic fill_zero;
    logic rd_done;
    logic out_busy;
    logic out_last;
  } csr_stat_t;

endpackage

// ----- rtl/csr_ctrl.sv -----
// Controller of the CAN segment reassembler: sequences check, write and read-out.
// Depends on csr_pkg for the command and status structs.
module csr_ctrl
  import csr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  csr_stat_t stat,
  output csr_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_WRITE  = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;
  localparam logic [2:0] ST_WAIT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (!stat.filt_ok || !stat.seq_ok) begin
          state_nxt = ST_IDLE;
        end else if (stat.fits) begin
          state_nxt = ST_WRITE;
        end else if (stat.done) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WRITE: begin
        cmd.wr = 1'b1;
        if (stat.wr_last) begin
          state_nxt = stat.done ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (stat.fill_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        if (stat.rd_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (!stat.out_busy) begin
          if (stat.out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/csr_datapath.sv -----
// Datapath of the CAN segment reassembler: filter, sequence state, byte buffer,
// chunk assembly and output register. Depends on csr_pkg.
module csr_datapath
  import csr_pkg::*;
#(
  parameter int BUF_BYTES = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [ID_W-1:0]  cfg_wr_data,
  input  logic [IN_W-1:0]  in_tdata,
  input  csr_cmd_t         cmd,
  output csr_stat_t        stat,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int FW = $clog2(BUF_BYTES + 1);
  localparam int AW = $clog2(BUF_BYTES);

  // Configuration and sequence state.
  logic [ID_W-1:0] base_r;
  logic [FW-1:0]   fill_r;
  logic [3:0]      exp_r;
  logic            inmsg_r;
  logic            done_r;

  // Latched frame.
  logic [ID_W-1:0] id_r;
  logic [3:0]      dlc_r;
  logic [7:0]      hdr_r;
  logic [7:0]      dat_r [7];
  logic [2:0]      k_r;

  // Buffer and read-out.
  logic [7:0]      mem [BUF_BYTES];
  logic [7:0]      mem_q_r;
  logic [7:0]      type_r;
  logic [FW-1:0]   plen_r;
  logic [3:0]      chunk_r;
  logic [3:0]      j_r;
  logic            cap_v_r;
  logic [2:0]      cap_pos_r;
  logic [7:0]      cbuf_r [8];

  // Output register.
  logic            out_valid_r;
  logic [7:0]      out_type_r;
  logic [7:0]      out_b_r [8];
  logic [3:0]      out_cnt_r;
  logic            out_last_r;
  logic [6:0]      out_plen_r;

  // Header evaluation.
  logic [3:0]       seq;
  logic [3:0]       total;
  logic             seq0;
  logic [3:0]       exp_base;
  logic [4:0]       exp_inc;
  logic             done_c;
  logic [3:0]       dlc_c;
  logic [2:0]       n_c;
  logic [FW-1:0]    fill_base;
  logic [CMP_W-1:0] fill_end;
  logic             in_win;

  assign seq       = hdr_r[7:4];
  assign total     = hdr_r[3:0];
  assign seq0      = (seq == 4'd0);
  assign exp_base  = seq0 ? 4'd0 : exp_r;
  assign exp_inc   = {1'b0, exp_base} + 5'd1;
  assign done_c    = (exp_inc >= {1'b0, total});
  assign dlc_c     = (dlc_r > MAX_DLC) ? MAX_DLC : dlc_r;
  assign n_c       = 3'(dlc_c - 4'd1);
  assign fill_base = seq0 ? '0 : fill_r;
  assign fill_end  = CMP_W'(fill_base) + CMP_W'(n_c);
  assign in_win    = (id_r >= base_r) && ({1'b0, id_r} < ({1'b0, base_r} + ID_WINDOW));

  // Chunk geometry.
  logic [CMP_W-1:0] off_e;
  logic [CMP_W-1:0] plen_e;
  logic [CMP_W-1:0] rem_e;
  logic [3:0]       cnt_c;
  logic             last_c;
  logic [CMP_W-1:0] rd_addr_e;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;

  assign off_e  = CMP_W'({chunk_r, 3'b000});
  assign plen_e = CMP_W'(plen_r);
  assign rem_e  = plen_e - off_e;
  assign cnt_c  = (plen_e >= off_e + CMP_W'(CHUNK_BYTES)) ? CHUNK_BYTES :
                  (plen_e > off_e) ? rem_e[3:0] : 4'd0;
  assign last_c = (chunk_r == LAST_CHUNK_IDX) || (off_e + CMP_W'(CHUNK_BYTES) >= plen_e);

  // Byte 0 of the buffer holds the type, so the payload starts one further on.
  assign rd_addr_e = CMP_W'(1) + off_e + CMP_W'(j_r);
  assign rd_addr   = rd_addr_e[AW-1:0];
  assign rd_en     = cmd.rd && (j_r < cnt_c);

  always_comb begin
    stat           = '0;
    stat.filt_ok   = in_win && (dlc_r >= MIN_DLC);
    stat.seq_ok    = seq0 || (inmsg_r && (seq == exp_r));
    stat.fits      = (fill_end <= CMP_W'(BUF_BYTES));
    stat.done      = cmd.check ? done_c : done_r;
    stat.wr_last   = (k_r == n_c - 3'd1);
    stat.fill_zero = (fill_r == '0);
    stat.rd_done   = (j_r == CHUNK_BYTES);
    stat.out_busy  = out_valid_r;
    stat.out_last  = out_last_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= RX_ID_BASE_RST;
      fill_r      <= '0;
      exp_r       <= '0;
      inmsg_r     <= 1'b0;
      done_r      <= 1'b0;
      cap_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (cmd.check && stat.filt_ok) begin
        if (stat.seq_ok) begin
          fill_r  <= fill_base;
          exp_r   <= done_c ? 4'd0 : exp_inc[3:0];
          inmsg_r <= !done_c;
          done_r  <= done_c;
        end else begin
          inmsg_r <= 1'b0;
          done_r  <= 1'b0;
        end
      end else if (cmd.check) begin
        done_r <= 1'b0;
      end
      if (cmd.wr) begin
        fill_r <= FW'(fill_r + 1'b1);
      end
      cap_v_r <= rd_en;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      id_r   <= in_tdata[28:0];
      dlc_r  <= in_tdata[32:29];
      hdr_r  <= in_tdata[40:33];
      dat_r[0] <= in_tdata[48:41];
      dat_r[1] <= in_tdata[56:49];
      dat_r[2] <= in_tdata[64:57];
      dat_r[3] <= in_tdata[72:65];
      dat_r[4] <= in_tdata[80:73];
      dat_r[5] <= in_tdata[88:81];
      dat_r[6] <= in_tdata[96:89];
      k_r    <= 3'd0;
    end else if (cmd.wr) begin
      k_r <= 3'(k_r + 3'd1);
    end
    if (cmd.wr && (fill_r == '0)) begin
      type_r <= dat_r[k_r];
    end
    if (cmd.start) begin
      plen_r <= FW'(fill_r - 1'b1);
    end
    if (cmd.start || cmd.next) begin
      chunk_r <= cmd.start ? 4'd0 : 4'(chunk_r + 4'd1);
      j_r     <= 4'd0;
      for (int i = 0; i < 8; i++) begin
        cbuf_r[i] <= 8'd0;
      end
    end else begin
      if (cmd.rd && !stat.rd_done) begin
        j_r <= 4'(j_r + 4'd1);
      end
      if (cap_v_r) begin
        cbuf_r[cap_pos_r] <= mem_q_r;
      end
    end
    cap_pos_r <= j_r[2:0];
    if (cmd.emit) begin
      out_type_r <= type_r;
      out_b_r    <= cbuf_r;
      out_cnt_r  <= cnt_c;
      out_last_r <= last_c;
      out_plen_r <= plen_e[6:0];
    end
  end

  // Byte buffer: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[fill_r[AW-1:0]] <= dat_r[k_r];
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_plen_r, out_cnt_r,
                       out_b_r[7], out_b_r[6], out_b_r[5], out_b_r[4],
                       out_b_r[3], out_b_r[2], out_b_r[1], out_b_r[0], out_type_r};

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (CMP_W'(fill_r) < CMP_W'(BUF_BYTES)))
    else $error("payload byte written past the end of the buffer");

  a_rd_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_addr_e < CMP_W'(fill_r)))
    else $error("chunk read beyond the filled part of the buffer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r)
    else $error("output register reloaded before its word was taken");

  a_msg_expects: assert property (@(posedge clk) disable iff (!rst_n)
    inmsg_r |-> (exp_r != 4'd0))
    else $error("open message with expected sequence zero");

endmodule

// ----- rtl/can_segment_reassembler.sv -----
// Top level of the CAN segment reassembler: joins controller and datapath.
// Depends on csr_pkg, csr_ctrl and csr_datapath.
//
//   channel  direction  handshake              contents
//   in_      slave      in_tvalid/in_tready    one received CAN frame per word
//   out_     master     out_tvalid/out_tready  one 8-byte chunk per word, tlast on last
//   cfg_     write      cfg_wr_en              rx_id_base, no read-back
//
// Each frame is latched and checked against the filter and the sequence state; if it
// passes and fits, its payload bytes are written one by one. A completing frame then
// has each chunk gathered byte by byte through the single read port of the buffer.
// Only one frame is in work at a time; a stalled output holds the block in its wait.
// Reset is synchronous and active low; the buffer needs no clearing pass.
module can_segment_reassembler
  import csr_pkg::*;
#(
  parameter int BUF_BYTES = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [ID_W-1:0]  cfg_wr_data,   // rx_id_base
  input  logic             in_tvalid,
  output logic             in_tready,
  // frame_id[28:0], dlc[32:29], header_byte[40:33], data1..data7 [96:41], zero [103:97]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // msg_type[7:0], out_b0..out_b7 [71:8], chunk_bytes[75:72], payload_length[82:76],
  // zero [87:83]
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast      // last_chunk
);

  csr_cmd_t  cmd;
  csr_stat_t stat;

  csr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csr_datapath #(
    .BUF_BYTES (BUF_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
